### rtl/core/lfd_pkg.sv
// Package for the display frame deframer: frame geometry, character codes,
// the queue item type and the sequencer state type.
// No dependencies; imported by every module of the block.
package lfd_pkg;

  localparam int FRAME_LEN   = 36;
  localparam int MARKER_POS  = 18;
  localparam int LINE_WIDTH  = 16;

  localparam int IDX_W  = $clog2(FRAME_LEN);
  localparam int FILL_W = $clog2(FRAME_LEN + 1);
  localparam int COL_W  = $clog2(LINE_WIDTH);
  localparam int SUM_W  = IDX_W + 2;

  localparam bit MARKER_OK = (MARKER_POS + 1 < FRAME_LEN);

  localparam logic [7:0] NEWLINE_CH = 8'h0A;
  localparam logic [7:0] BRACKET_CH = 8'h5B;
  localparam logic [7:0] H_CH       = 8'h48;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0] data;
    logic       is_nl;
  } rx_item_t;

  typedef enum logic [2:0] {
    ST_CAPTURE,
    ST_SCAN,
    ST_DECIDE,
    ST_SKIP_TOP,
    ST_EMIT_TOP,
    ST_SKIP_BOT,
    ST_EMIT_BOT,
    ST_ERROR
  } back_state_t;

endpackage

### rtl/core/lfd_front.sv
// Front end of the deframer: accepts received bytes, marks newlines and
// holds them in a short queue for the frame sequencer.
// Depends on lfd_pkg.
module lfd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             rx_valid,
  output logic             rx_stall,
  input  logic [7:0]       rx_byte,
  output logic             q_valid,
  output lfd_pkg::rx_item_t q_item,
  input  logic             q_pop
);
  import lfd_pkg::*;

  rx_item_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;

  assign rx_stall = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign q_item   = mem[rd_ptr];
  assign push     = rx_valid && !rx_stall;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{data: rx_byte, is_nl: (rx_byte == NEWLINE_CH)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W + 1)'(1);
        2'b01:   count <= count - (QPTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/core/lfd_back.sv
// Back end of the deframer: frame window shift line, validity scan, marker
// search, character emission, error count and the result register.
// Depends on lfd_pkg; fed by lfd_front.
module lfd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  lfd_pkg::rx_item_t q_item,
  output logic              q_pop,
  output logic              res_valid,
  input  logic              res_stall,
  output logic [7:0]        screen_char,
  output logic              line_select,
  output logic [3:0]        column,
  output logic              frame_bad,
  output logic [15:0]       bad_frame_total,
  output logic              last
);
  import lfd_pkg::*;

  back_state_t       state;
  back_state_t       state_next;
  logic [7:0]        win [FRAME_LEN];
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  p;
  logic [IDX_W-1:0]  nl;
  logic              p_found;
  logic              nl_found;
  logic              zero_seen;
  logic              mark_ok;
  logic [FILL_W-1:0] fill;
  logic              capturing;
  logic [15:0]       err_cnt;
  logic [COL_W-1:0]  col;

  logic              out_free;
  logic              pair_now;
  logic [IDX_W:0]    tgt;
  logic [SUM_W-1:0]  top_sum;
  logic              frame_done;
  logic              col_last;
  logic              skip_top_done;
  logic [15:0]       err_inc;

  logic              take;
  logic              shift_in;
  logic              rotate;
  logic              emit;
  logic [7:0]        emit_char;
  logic              emit_line;
  logic [3:0]        emit_col;
  logic              emit_bad;
  logic              emit_last;

  assign out_free      = !res_valid || !res_stall;
  assign pair_now      = (win[0] == BRACKET_CH) && (win[1] == H_CH);
  assign tgt           = (IDX_W + 1)'(p) + (IDX_W + 1)'(2);
  assign top_sum       = SUM_W'(tgt) + SUM_W'(col);
  assign frame_done    = capturing && (fill == FILL_W'(FRAME_LEN - 1));
  assign col_last      = (col == COL_W'(LINE_WIDTH - 1));
  assign skip_top_done = (tgt >= (IDX_W + 1)'(FRAME_LEN)) || (tgt == {1'b0, idx});
  assign err_inc       = (err_cnt == 16'hFFFF) ? err_cnt : err_cnt + 16'd1;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CAPTURE: begin
        if (q_valid && frame_done) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx == IDX_W'(FRAME_LEN - 1)) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_next = (!zero_seen && mark_ok) ? ST_SKIP_TOP : ST_ERROR;
      end
      ST_SKIP_TOP: begin
        if (skip_top_done) begin
          state_next = ST_EMIT_TOP;
        end
      end
      ST_EMIT_TOP: begin
        if (out_free && col_last) begin
          state_next = ST_SKIP_BOT;
        end
      end
      ST_SKIP_BOT: begin
        if (idx == IDX_W'(1)) begin
          state_next = ST_EMIT_BOT;
        end
      end
      ST_EMIT_BOT: begin
        if (out_free && col_last) begin
          state_next = ST_CAPTURE;
        end
      end
      ST_ERROR: begin
        if (out_free) begin
          state_next = ST_CAPTURE;
        end
      end
      default: state_next = ST_CAPTURE;
    endcase
  end

  always_comb begin
    take      = 1'b0;
    shift_in  = 1'b0;
    rotate    = 1'b0;
    emit      = 1'b0;
    emit_char = 8'd0;
    emit_line = 1'b0;
    emit_col  = 4'(col);
    emit_bad  = 1'b0;
    emit_last = 1'b0;
    unique case (state)
      ST_CAPTURE: begin
        take     = q_valid;
        shift_in = q_valid && (capturing || q_item.is_nl);
      end
      ST_SCAN: begin
        rotate = 1'b1;
      end
      ST_DECIDE: begin
        rotate = 1'b0;
      end
      ST_SKIP_TOP: begin
        rotate = !skip_top_done;
      end
      ST_EMIT_TOP: begin
        emit      = out_free;
        rotate    = out_free;
        emit_char = (top_sum < SUM_W'(FRAME_LEN)) ? win[0] : 8'd0;
      end
      ST_SKIP_BOT: begin
        rotate = (idx != IDX_W'(1));
      end
      ST_EMIT_BOT: begin
        emit      = out_free;
        rotate    = out_free;
        emit_line = 1'b1;
        emit_char = (SUM_W'(col) + SUM_W'(1) < SUM_W'(FRAME_LEN)) ? win[0] : 8'd0;
        emit_last = col_last;
      end
      ST_ERROR: begin
        emit      = out_free;
        emit_col  = 4'd0;
        emit_bad  = 1'b1;
        emit_last = 1'b1;
      end
      default: begin
        rotate = 1'b0;
      end
    endcase
  end

  assign q_pop = take;

  always_ff @(posedge clk) begin
    if (shift_in || rotate) begin
      for (int k = 0; k < FRAME_LEN - 1; k++) begin
        win[k] <= win[k + 1];
      end
      win[FRAME_LEN - 1] <= shift_in ? q_item.data : win[0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CAPTURE) begin
      idx       <= '0;
      p         <= IDX_W'(MARKER_POS);
      p_found   <= 1'b0;
      nl        <= '0;
      nl_found  <= 1'b0;
      zero_seen <= 1'b0;
      mark_ok   <= 1'b0;
    end else begin
      if (rotate) begin
        idx <= (idx == IDX_W'(FRAME_LEN - 1)) ? '0 : idx + IDX_W'(1);
      end
      if (state == ST_SCAN) begin
        if (idx != '0 && win[0] == 8'd0) begin
          zero_seen <= 1'b1;
        end
        if (MARKER_OK && idx == IDX_W'(MARKER_POS) && pair_now) begin
          mark_ok <= 1'b1;
        end
        if (!p_found && idx != '0 && idx <= IDX_W'(FRAME_LEN - 2) && pair_now) begin
          p       <= idx;
          p_found <= 1'b1;
        end
        if (!nl_found && idx != '0 && win[0] == NEWLINE_CH) begin
          nl       <= idx;
          nl_found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SKIP_TOP || state == ST_SKIP_BOT) begin
      col <= '0;
    end else if (emit) begin
      col <= col + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      screen_char     <= emit_char;
      line_select     <= emit_line;
      column          <= emit_col;
      frame_bad       <= emit_bad;
      bad_frame_total <= emit_bad ? err_inc : err_cnt;
      last            <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CAPTURE;
      capturing <= 1'b0;
      fill      <= '0;
      err_cnt   <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (take) begin
        if (capturing) begin
          fill <= fill + FILL_W'(1);
        end else if (q_item.is_nl) begin
          capturing <= 1'b1;
          fill      <= FILL_W'(1);
        end
      end
      if (state == ST_EMIT_BOT && out_free && col_last) begin
        capturing <= 1'b0;
        fill      <= '0;
      end
      if (state == ST_ERROR && out_free) begin
        err_cnt <= err_inc;
        if (nl_found) begin
          fill <= FILL_W'(FRAME_LEN) - FILL_W'(nl);
        end else begin
          capturing <= 1'b0;
          fill      <= '0;
        end
      end
      if (emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  a_pop_in_capture: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == ST_CAPTURE)
    else $error("queue popped outside capture");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_CAPTURE |-> fill < FILL_W'(FRAME_LEN))
    else $error("window fill count at or past frame length while capturing");

  a_bad_is_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && frame_bad |-> last)
    else $error("error result not marked as last");

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN && idx == IDX_W'(FRAME_LEN - 1) |=> state == ST_DECIDE)
    else $error("validity scan did not end after one full window");

endmodule

### rtl/core/lcd_frame_deframer_core.sv
// Display frame deframer, top level.
// Receive channel: rx_valid, rx_stall and rx_byte carry one serial byte per
// transaction. Result channel: res_valid and res_stall with screen_char,
// line_select, column, frame_bad, bad_frame_total and last.
// Bytes enter a four-entry queue and are taken by the frame sequencer at one
// per cycle while a frame is being captured; bytes before a newline are
// dropped. When the last of the 36 window bytes arrives, the sequencer scans
// the window and then decides. A valid frame then emits 32 characters, top
// line first, one per cycle when the receiver is not stalling, with rotation
// steps before each line. A rejected frame gives a single error result.
// While a frame is being scanned or emitted, incoming bytes fill the queue
// and then rx_stall rises. A stall on the result side holds the result
// register and the sequencer in its emit and error states; bytes are still
// queued until the queue is full.
// Reset clears the queue, the hunting state, the fill count and the error
// count; no results are pending after reset.
// Depends on lfd_pkg, lfd_front and lfd_back.
module lcd_frame_deframer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [7:0]  screen_char,
  output logic        line_select,
  output logic [3:0]  column,
  output logic        frame_bad,
  output logic [15:0] bad_frame_total,
  output logic        last
);
  import lfd_pkg::*;

  logic     q_valid;
  logic     q_pop;
  rx_item_t q_item;

  lfd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .rx_byte  (rx_byte),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  lfd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .res_valid       (res_valid),
    .res_stall       (res_stall),
    .screen_char     (screen_char),
    .line_select     (line_select),
    .column          (column),
    .frame_bad       (frame_bad),
    .bad_frame_total (bad_frame_total),
    .last            (last)
  );

endmodule
